FILE: rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants and types for the scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int COV_FRAC_BITS_DEF = 24;

    localparam int EST_W         = 32;  // estimate, signed Q16.16
    localparam int EST_FRAC_BITS = 16;
    localparam int COV_W         = 32;  // covariance and noise terms
    localparam int GAIN_W        = 25;  // gain output field

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [COV_W-1:0] Q_RESET = 32'd16777;
    localparam logic [COV_W-1:0] R_RESET = 32'd1677722;

    localparam int P_RESET_UNITS = 5;        // initial covariance, 5.0
    localparam int FLOOR_DIV     = 1000000;  // floor is one millionth

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE = 8'd0,
        REG_MEAS_NOISE    = 8'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_UPD
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/skf_if.sv
// ----------------------------------------------------------------------------
// skf_if
// Valid/ready channels of the scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_meas_if
    import skf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_res_if
    import skf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [EST_W-1:0] estimate;
    logic [GAIN_W-1:0]       gain;

    modport source (output valid, output estimate, output gain, input ready);
    modport sink   (input valid, input estimate, input gain, output ready);
endinterface

interface skf_cfg_if
    import skf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div
// Radix-2 restoring divider: quotient floor((num << F) / den), one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div
    import skf_pkg::*;
#(
    parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COV_W-1:0]       i_num,
    input  logic [COV_W:0]         i_den,
    output logic [COV_FRAC_BITS:0] o_quot,
    output logic                   o_done
);

    localparam int QW = COV_FRAC_BITS + 1;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_first, n_first;
    logic          r_zero, n_zero;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [COV_W:0] r_rem, n_rem;
    logic [COV_W:0] r_den, n_den;
    logic [QW-1:0]  r_quot, n_quot;

    logic [COV_W+1:0] trial;
    logic [COV_W+1:0] sub;
    logic             ge;

    // first step compares the numerator itself (quotient bit of weight one)
    assign trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign sub   = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_first = r_first;
        n_zero  = r_zero;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quot  = r_quot;
        if (i_start) begin
            n_busy  = 1'b1;
            n_first = 1'b1;
            n_zero  = (i_den == '0);
            n_cnt   = CW'(QW);
            n_rem   = {1'b0, i_num};
            n_den   = i_den;
        end else if (r_busy) begin
            n_first = 1'b0;
            n_rem   = ge ? sub[COV_W:0] : trial[COV_W:0];
            n_quot  = {r_quot[QW-2:0], ge};
            n_cnt   = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_first <= n_first;
        r_zero  <= n_zero;
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quot  <= n_quot;
    end

    // zero denominator gives a gain of one
    assign o_quot = r_zero ? {1'b1, {COV_FRAC_BITS{1'b0}}} : r_quot;
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/skf_mul.sv
// ----------------------------------------------------------------------------
// skf_mul
// Serial shift-add multiplier, signed multiplicand by unsigned multiplier,
// one multiplier bit a cycle; result is the product shifted right by KW-1.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul
    import skf_pkg::*;
#(
    parameter int MW = EST_W + 1,
    parameter int KW = COV_FRAC_BITS_DEF + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [MW-1:0] i_mcand,
    input  logic [KW-1:0]        i_mplier,
    output logic signed [MW+2:0] o_prod,
    output logic                 o_done
);

    localparam int CW = $clog2(KW + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic signed [MW-1:0] r_mc, n_mc;
    logic signed [MW+1:0] r_hi, n_hi;
    logic [KW-1:0]        r_lo, n_lo;   // multiplier out, product bits in

    logic signed [MW+1:0] sum;

    assign sum = r_hi + (r_lo[0] ? {{2{r_mc[MW-1]}}, r_mc} : '0);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_mc   = r_mc;
        n_hi   = r_hi;
        n_lo   = r_lo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(KW);
            n_mc   = i_mcand;
            n_hi   = '0;
            n_lo   = i_mplier;
        end else if (r_busy) begin
            n_hi  = {sum[MW+1], sum[MW+1:1]};
            n_lo  = {sum[0], r_lo[KW-1:1]};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_mc  <= n_mc;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
    end

    // arithmetic shift right by KW-1: floor towards minus infinity
    assign o_prod = {r_hi, r_lo[KW-1]};
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter (random walk, A = H = 1) in fixed point.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                                  Handshake
// i_meas    in   measurement (SAMPLE_WIDTH, signed)       valid/ready
// o_res     out  estimate (32, Q16.16), gain (25, Q1.24)  valid/ready
// i_cfg     in   index (8), data (32)                     valid/ready
//
// One request is taken at a time: the next acceptance waits until the
// previous request has passed the bit-serial gain divider and the
// bit-serial update multipliers, which run one after the other.
// Reset (synchronous, active low) loads Q, R, x = 0 and P = 5.0.
// The result sits in an output register; if it has not been taken when the
// next result is ready, the update step waits.
// Configuration writes are always accepted; unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    skf_meas_if.sink    i_meas,
    skf_res_if.source   o_res,
    skf_cfg_if.sink     i_cfg
);

    localparam int KW = COV_FRAC_BITS + 1;        // gain width, up to 1.0
    localparam int ZW = SAMPLE_WIDTH + EST_FRAC_BITS;
    localparam int WW = ((ZW > EST_W) ? ZW : EST_W) + 1;
    localparam int PW = EST_W + 4;                // multiplier result width
    localparam int XW = EST_W + 5;

    // covariance constants in Q.COV_FRAC_BITS
    localparam logic [63:0] ONE64    = 64'd1 << COV_FRAC_BITS;
    localparam logic [63:0] PRST64   = ONE64 * 64'(P_RESET_UNITS);
    localparam logic [63:0] FLOOR64  = (ONE64 + 64'(FLOOR_DIV / 2)) / 64'(FLOOR_DIV);
    localparam logic [COV_W-1:0] P_RESET =
        (PRST64 > 64'hFFFF_FFFF) ? '1 : PRST64[COV_W-1:0];
    localparam logic [COV_W-1:0] COV_FLOOR = FLOOR64[COV_W-1:0];

    // saturation bounds of the widened sample and of the new estimate
    localparam logic signed [WW-1:0] Z_MAX =
        {{(WW-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}};
    localparam logic signed [WW-1:0] Z_MIN =
        {{(WW-EST_W+1){1'b1}}, {(EST_W-1){1'b0}}};
    localparam logic signed [XW-1:0] X_MAX =
        {{(XW-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}};
    localparam logic signed [XW-1:0] X_MIN =
        {{(XW-EST_W+1){1'b1}}, {(EST_W-1){1'b0}}};

    // ---- state ----
    t_state r_state, n_state;

    logic [COV_W-1:0]        r_q, r_r;       // noise registers
    logic signed [EST_W-1:0] r_x, n_x;       // estimate
    logic [COV_W-1:0]        r_pcov, n_pcov; // covariance between requests

    // working registers of one request
    logic signed [EST_W-1:0] r_z, n_z;
    logic [COV_W-1:0]        r_p, n_p;       // predicted covariance
    logic signed [EST_W:0]   r_diff, n_diff; // z - x
    logic [KW-1:0]           r_k, n_k;

    // output register
    logic                    r_ovalid, n_ovalid;
    logic signed [EST_W-1:0] r_oest, n_oest;
    logic [GAIN_W-1:0]       r_ogain, n_ogain;

    // ---- control ----
    logic in_acc, out_free, div_start, mul_start, upd_fire;
    logic div_done, mul_e_done, mul_p_done;
    logic [KW-1:0]        div_quot;
    logic signed [PW-1:0] corr;   // floor(K * (z - x) >> F)
    logic signed [PW-1:0] kp;     // (K * P) >> F

    assign in_acc   = i_meas.valid && i_meas.ready;
    assign out_free = !r_ovalid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_PRED;
            ST_PRED:  n_state = ST_SETUP;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_MUL;
            ST_MUL:   if (mul_e_done && mul_p_done) n_state = ST_UPD;
            ST_UPD:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state decoded controls
    always_comb begin
        i_meas.ready = 1'b0;
        div_start    = 1'b0;
        mul_start    = 1'b0;
        upd_fire     = 1'b0;
        case (r_state)
            ST_IDLE:  i_meas.ready = 1'b1;
            ST_SETUP: div_start    = 1'b1;
            ST_DIV:   mul_start    = div_done;
            ST_UPD:   upd_fire     = out_free;
            default:  ;
        endcase
    end

    // ---- configuration ----
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= Q_RESET;
            r_r <= R_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                REG_PROCESS_NOISE: r_q <= i_cfg.data[COV_W-1:0];
                REG_MEAS_NOISE:    r_r <= i_cfg.data[COV_W-1:0];
                default:           ;
            endcase
        end
    end

    // ---- datapath ----
    logic signed [ZW-1:0] z_wide;
    logic signed [WW-1:0] z_ext;
    logic [COV_W:0]       p_sum;
    logic signed [XW-1:0] x_sum;
    logic [COV_W-1:0]     p_sub;
    logic [COV_W:0]       den;

    // sample to Q16.16, saturated to 32 bits for wide samples
    assign z_wide = $signed({i_meas.measurement, {EST_FRAC_BITS{1'b0}}});
    assign z_ext  = {{(WW-ZW){z_wide[ZW-1]}}, z_wide};
    // predict with saturation at the 32-bit maximum
    assign p_sum  = {1'b0, r_pcov} + {1'b0, r_q};
    // gain denominator at 33 bits, so K never exceeds one
    assign den    = {1'b0, r_p} + {1'b0, r_r};
    assign x_sum  = {{(XW-EST_W){r_x[EST_W-1]}}, r_x} + {corr[PW-1], corr};
    assign p_sub  = r_p - kp[COV_W-1:0];

    always_comb begin
        n_z      = r_z;
        n_p      = r_p;
        n_diff   = r_diff;
        n_k      = r_k;
        n_x      = r_x;
        n_pcov   = r_pcov;
        n_ovalid = r_ovalid && !o_res.ready;
        n_oest   = r_oest;
        n_ogain  = r_ogain;

        if (in_acc) begin
            if (z_ext > Z_MAX) begin
                n_z = Z_MAX[EST_W-1:0];
            end else if (z_ext < Z_MIN) begin
                n_z = Z_MIN[EST_W-1:0];
            end else begin
                n_z = z_ext[EST_W-1:0];
            end
        end

        if (r_state == ST_PRED) begin
            n_p    = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
            n_diff = {r_z[EST_W-1], r_z} - {r_x[EST_W-1], r_x};
        end

        if (div_done) begin
            n_k = div_quot;
        end

        if (upd_fire) begin
            if (x_sum > X_MAX) begin
                n_x = X_MAX[EST_W-1:0];
            end else if (x_sum < X_MIN) begin
                n_x = X_MIN[EST_W-1:0];
            end else begin
                n_x = x_sum[EST_W-1:0];
            end
            // shrink, clip at zero, then floor
            if ($unsigned(kp) > {{(PW-COV_W){1'b0}}, r_p}) begin
                n_pcov = COV_FLOOR;
            end else if (p_sub < COV_FLOOR) begin
                n_pcov = COV_FLOOR;
            end else begin
                n_pcov = p_sub;
            end
            n_ovalid = 1'b1;
            n_oest   = n_x;
            n_ogain  = GAIN_W'(r_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_x      <= '0;
            r_pcov   <= P_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_x      <= n_x;
            r_pcov   <= n_pcov;
        end
        r_z     <= n_z;
        r_p     <= n_p;
        r_diff  <= n_diff;
        r_k     <= n_k;
        r_oest  <= n_oest;
        r_ogain <= n_ogain;
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.estimate = r_oest;
    assign o_res.gain     = r_ogain;

    // ---- serial units ----
    skf_div #(
        .COV_FRAC_BITS (COV_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_p),
        .i_den   (den),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    // K * (z - x)
    skf_mul #(
        .MW (EST_W + 1),
        .KW (KW)
    ) u_mul_est (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (r_diff),
        .i_mplier (div_quot),
        .o_prod   (corr),
        .o_done   (mul_e_done)
    );

    // K * P
    skf_mul #(
        .MW (COV_W + 1),
        .KW (KW)
    ) u_mul_cov (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  ($signed({1'b0, r_p})),
        .i_mplier (div_quot),
        .o_prod   (kp),
        .o_done   (mul_p_done)
    );

endmodule

`default_nettype wire

FILE: rtl/skf_checker.sv
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks of the scalar Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_checker
    import skf_pkg::*;
#(
    parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [EST_W-1:0] i_estimate,
    input logic [GAIN_W-1:0]       i_gain
);

    localparam logic [GAIN_W-1:0] GAIN_MAX =
        (COV_FRAC_BITS < GAIN_W) ? GAIN_W'(64'd1 << COV_FRAC_BITS) : '1;

    // a pending result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // and its payload does not move
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_estimate) && $stable(i_gain))
        else $error("result payload changed while stalled");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");

    // gain never exceeds one
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_gain <= GAIN_MAX)
        else $error("gain above one");

endmodule

bind scalar_kalman_filter skf_checker #(
    .COV_FRAC_BITS (COV_FRAC_BITS)
) u_skf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_meas.valid),
    .i_in_ready  (i_meas.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_estimate  (o_res.estimate),
    .i_gain      (o_res.gain)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scalar Kalman filter. Samples and register
// writes are queued up front and fed by a clocked driver with random gaps.
// A bit-accurate predictor of the filter works out the estimate and gain
// for every accepted sample. A clocked monitor with random back-pressure
// compares each result against the oldest prediction.
// ----------------------------------------------------------------------------

module tb;
    import skf_pkg::*;

    // Timing and run control
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_WAIT      = 12;    // longest gap / stall per request
    localparam int SETTLE_CYCLES = 64;    // pause before register writes
    localparam int STALL_LIMIT   = 5000;  // cycles without any handshake
    localparam int RANDOM_ITEMS  = 1330;

    // Fixed-point constants of the filter
    localparam longint unsigned COV_ONE   = 64'd1 << COV_FRAC_BITS_DEF;
    localparam longint unsigned COV_FLOOR = (COV_ONE + FLOOR_DIV / 2) / FLOOR_DIV;
    localparam longint unsigned COV_MAX   = 64'hFFFF_FFFF;
    localparam longint unsigned P_INIT    = (COV_ONE * P_RESET_UNITS > COV_MAX)
                                            ? COV_MAX : COV_ONE * P_RESET_UNITS;
    localparam longint          EST_MAX   = 64'sh7FFF_FFFF;
    localparam longint          EST_MIN   = -64'sh8000_0000;

    // Register indexes past the known ones are ignored by the block
    localparam int UNKNOWN_IDX_LO = int'(REG_MEAS_NOISE) + 1;
    localparam int UNKNOWN_IDX_HI = (1 << CFG_IDX_W) - 1;

    localparam int SAMPLE_MAX = (1 << (SAMPLE_WIDTH_DEF - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_WIDTH_DEF - 1));

    typedef logic signed [SAMPLE_WIDTH_DEF-1:0] t_sample;

    typedef enum logic [1:0] {
        JOB_SAMPLE,
        JOB_WRITE,
        JOB_DRAIN    // hold off until every result is back, then settle
    } t_job_kind;

    typedef struct {
        t_job_kind             kind;
        t_sample               sample;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        bit                    calm;     // no gap before the next request
    } t_job;

    typedef struct packed {
        logic signed [EST_W-1:0] estimate;
        logic [GAIN_W-1:0]       gain;
    } t_filter_out;

    logic i_clk;
    logic i_rst_n;

    skf_meas_if meas_if ();
    skf_res_if  res_if ();
    skf_cfg_if  cfg_if ();

    scalar_kalman_filter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meas  (meas_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_job        pending_jobs[$];
    t_filter_out expected_outputs[$];
    int          error_count;
    int          results_seen;

    // Filter model state, kept in step with the block
    logic [COV_W-1:0]        q_mdl;
    logic [COV_W-1:0]        r_mdl;
    logic signed [EST_W-1:0] est_mdl;
    logic [COV_W-1:0]        cov_mdl;

    // ------------------------------------------------------------------------
    // Predictor: one filter step for an accepted sample.
    // Predict P, gain K = (P << F) / (P + R), correct x, shrink P and floor it.
    // ------------------------------------------------------------------------
    function automatic t_filter_out advance_filter(input t_sample sample);
        longint unsigned p_pred;
        longint unsigned denom;
        longint unsigned k;
        longint unsigned kp;
        longint          z;
        longint          diff;
        longint          x;
        t_filter_out     res;
        // covariance prediction saturates at the 32-bit ceiling
        p_pred = 64'(cov_mdl) + 64'(q_mdl);
        if (p_pred > COV_MAX) begin
            p_pred = COV_MAX;
        end
        // 33-bit denominator keeps K at or below one
        denom = p_pred + 64'(r_mdl);
        if (denom == 0) begin
            k = COV_ONE;
        end else begin
            k = (p_pred << COV_FRAC_BITS_DEF) / denom;
        end
        z    = longint'(sample) <<< EST_FRAC_BITS;
        diff = z - longint'(est_mdl);
        // arithmetic shift: negative corrections round toward minus infinity
        x = longint'(est_mdl) + ((longint'(k) * diff) >>> COV_FRAC_BITS_DEF);
        if (x > EST_MAX) begin
            x = EST_MAX;
        end
        if (x < EST_MIN) begin
            x = EST_MIN;
        end
        est_mdl = x[EST_W-1:0];
        kp = (k * p_pred) >> COV_FRAC_BITS_DEF;
        p_pred = (kp > p_pred) ? 64'd0 : p_pred - kp;
        if (p_pred < COV_FLOOR) begin
            p_pred = COV_FLOOR;
        end
        cov_mdl = p_pred[COV_W-1:0];
        res.estimate = est_mdl;
        res.gain     = k[GAIN_W-1:0];
        return res;
    endfunction

    function automatic void write_model_reg(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_reg'(idx))
            REG_PROCESS_NOISE: q_mdl = data;
            REG_MEAS_NOISE:    r_mdl = data;
            default: ;  // unknown index, no effect
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_sample(input t_sample s, input bit calm);
        t_job j;
        j.kind = JOB_SAMPLE;  j.sample = s;  j.calm = calm;
        j.reg_idx = '0;       j.reg_data = '0;
        pending_jobs.push_back(j);
    endfunction

    function automatic void queue_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        t_job j;
        j.kind = JOB_WRITE;  j.reg_idx = idx;  j.reg_data = data;
        j.sample = '0;       j.calm = 1'b0;
        pending_jobs.push_back(j);
    endfunction

    // Registers may only change once the block has gone quiet
    function automatic void queue_drain();
        t_job j;
        j.kind = JOB_DRAIN;  j.sample = '0;  j.calm = 1'b0;
        j.reg_idx = '0;      j.reg_data = '0;
        pending_jobs.push_back(j);
    endfunction

    // Noise settings: extremes, tiny, typical and fully random
    function automatic logic [CFG_DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            3:       return $urandom_range(0, 4096);
            default: return $urandom_range(1 << 16, 1 << 26);
        endcase
    endfunction

    function automatic t_sample clamp_sample(input int v);
        if (v > SAMPLE_MAX) begin
            return t_sample'(SAMPLE_MAX);
        end
        if (v < SAMPLE_MIN) begin
            return t_sample'(SAMPLE_MIN);
        end
        return t_sample'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driver: takes jobs in order. Samples and writes go out on their own
    // channels; a drain job holds everything back until the results are in.
    // ------------------------------------------------------------------------
    int send_gap;
    int settle_count;

    always @(posedge i_clk) begin : driver
        bit   m_vld;
        bit   c_vld;
        t_job job;
        m_vld = meas_if.valid;
        c_vld = cfg_if.valid;
        if (!i_rst_n) begin
            meas_if.valid <= 1'b0;
            cfg_if.valid  <= 1'b0;
            send_gap      <= 0;
            settle_count  <= 0;
        end else begin
            if (m_vld && meas_if.ready) begin
                expected_outputs.push_back(advance_filter(meas_if.measurement));
                m_vld = 1'b0;
            end
            if (c_vld && cfg_if.ready) begin
                write_model_reg(cfg_if.index, cfg_if.data);
                c_vld = 1'b0;
            end
            if (!m_vld && !c_vld && pending_jobs.size() != 0) begin
                job = pending_jobs[0];
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                end else begin
                    case (job.kind)
                        JOB_SAMPLE: begin
                            meas_if.measurement <= job.sample;
                            m_vld = 1'b1;
                            void'(pending_jobs.pop_front());
                            send_gap <= job.calm ? 0 : $urandom_range(0, MAX_WAIT);
                        end
                        JOB_WRITE: begin
                            cfg_if.index <= job.reg_idx;
                            cfg_if.data  <= job.reg_data;
                            c_vld = 1'b1;
                            void'(pending_jobs.pop_front());
                        end
                        JOB_DRAIN: begin
                            // quiet for a full settle window before moving on
                            if (expected_outputs.size() != 0) begin
                                settle_count <= 0;
                            end else if (settle_count >= SETTLE_CYCLES) begin
                                settle_count <= 0;
                                void'(pending_jobs.pop_front());
                            end else begin
                                settle_count <= settle_count + 1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            meas_if.valid <= m_vld;
            cfg_if.valid  <= c_vld;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure on the result channel, with calm
    // stretches where ready stays high.
    // ------------------------------------------------------------------------
    int take_gap;

    always @(posedge i_clk) begin : monitor
        bit          rdy;
        int          stall;
        t_filter_out exp_out;
        rdy = res_if.ready;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            take_gap     <= 0;
            results_seen <= 0;
        end else begin
            if (res_if.valid && rdy) begin
                results_seen <= results_seen + 1;
                if (expected_outputs.size() == 0) begin
                    $error("unexpected result: estimate %0d gain %0d",
                           res_if.estimate, res_if.gain);
                    error_count++;
                end else begin
                    exp_out = expected_outputs.pop_front();
                    if (res_if.estimate !== exp_out.estimate) begin
                        $error("estimate mismatch: expected %0d, actual %0d",
                               exp_out.estimate, res_if.estimate);
                        error_count++;
                    end
                    if (res_if.gain !== exp_out.gain) begin
                        $error("gain mismatch: expected %0d, actual %0d",
                               exp_out.gain, res_if.gain);
                        error_count++;
                    end
                end
                stall = ((results_seen % 150) < 40) ? 0 : $urandom_range(0, MAX_WAIT);
                take_gap <= stall;
                rdy = (stall == 0);
            end else if (take_gap != 0) begin
                take_gap <= take_gap - 1;
                rdy = (take_gap == 1);
            end else begin
                rdy = 1'b1;
            end
            res_if.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any request, write or result means a hang
    // ------------------------------------------------------------------------
    int idle_cycles;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((meas_if.valid && meas_if.ready) || (cfg_if.valid && cfg_if.ready)
                     || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("scalar_kalman_filter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int      queued;
        int      phase_len;
        int      level;
        bit      calm;
        t_sample s;

        error_count         = 0;
        i_rst_n             = 1'b0;
        meas_if.valid       = 1'b0;
        meas_if.measurement = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        res_if.ready        = 1'b0;

        q_mdl   = Q_RESET;
        r_mdl   = R_RESET;
        est_mdl = '0;
        cov_mdl = P_INIT[COV_W-1:0];

        // Directed: field extremes and sign flips at reset noise settings
        queue_sample(t_sample'(SAMPLE_MAX), 1'b0);
        queue_sample(t_sample'(SAMPLE_MIN), 1'b0);
        queue_sample('0, 1'b1);
        queue_sample(-1, 1'b1);
        queue_sample(1, 1'b0);
        queue_sample(100, 1'b0);
        queue_sample(-100, 1'b0);

        // Covariance saturates; with R at zero the gain is exactly one
        queue_drain();
        queue_write(REG_PROCESS_NOISE, '1);
        queue_write(REG_MEAS_NOISE, '0);
        queue_sample(t_sample'(SAMPLE_MAX), 1'b0);
        queue_sample(t_sample'(SAMPLE_MIN), 1'b1);
        queue_sample(7, 1'b0);

        // Huge R: tiny gain, slow pull toward the sample
        queue_drain();
        queue_write(REG_PROCESS_NOISE, '0);
        queue_write(REG_MEAS_NOISE, '1);
        queue_sample(5, 1'b0);
        queue_sample(-5, 1'b0);
        queue_sample(t_sample'(SAMPLE_MIN), 1'b0);

        // No noise at all: covariance collapses to the floor
        queue_drain();
        queue_write(REG_MEAS_NOISE, '0);
        queue_sample(-3, 1'b0);
        queue_sample(-3, 1'b1);
        queue_sample(12, 1'b0);

        // Writes to unknown indexes must leave Q and R alone
        queue_drain();
        queue_write(REG_MEAS_NOISE, R_RESET);
        queue_write(UNKNOWN_IDX_LO, $urandom());
        queue_write(UNKNOWN_IDX_HI, $urandom());
        queue_sample(-1000, 1'b0);
        queue_sample(999, 1'b0);

        // Random: phases of slowly drifting signal around a level, with
        // occasional outliers, each phase under fresh noise settings
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            queue_drain();
            queue_write(REG_PROCESS_NOISE, pick_noise());
            queue_write(REG_MEAS_NOISE, pick_noise());
            if ($urandom_range(0, 3) == 0) begin
                queue_write($urandom_range(UNKNOWN_IDX_LO, UNKNOWN_IDX_HI), $urandom());
            end
            phase_len = $urandom_range(20, 80);
            calm      = ($urandom_range(0, 3) == 0);
            level     = $urandom_range(0, SAMPLE_MAX - SAMPLE_MIN) + SAMPLE_MIN;
            for (int i = 0; i < phase_len; i++) begin
                case ($urandom_range(0, 9))
                    0:       s = t_sample'($urandom());
                    1:       s = $urandom_range(0, 1) ? t_sample'(SAMPLE_MAX)
                                                      : t_sample'(SAMPLE_MIN);
                    default: begin
                        level = level + $urandom_range(0, 8) - 4;
                        s = clamp_sample(level + $urandom_range(0, 64) - 32);
                    end
                endcase
                queue_sample(s, calm);
            end
            queued += phase_len;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_jobs.size() != 0 || meas_if.valid || cfg_if.valid) begin
            @(posedge i_clk);
        end
        while (expected_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_outputs.size() != 0) begin
            $error("%0d results never arrived", expected_outputs.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("scalar_kalman_filter regression: pass");
        end else begin
            $display("scalar_kalman_filter regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/skf_pkg.sv
rtl/skf_if.sv
rtl/skf_div.sv
rtl/skf_mul.sv
rtl/scalar_kalman_filter.sv
rtl/skf_checker.sv
dv/tb.sv
